// ----- rtl/lams_pkg.sv -----
// Shared types and constants for the load adaptive model selector.
`timescale 1ns / 1ps
package lams_pkg;

    // Field widths
    localparam int OCC_W   = 16;
    localparam int MODEL_W = 6;
    localparam int STEP_W  = 2;
    localparam int COUNT_W = 32;

    // Configuration port
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MODEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_MODEL  = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [MODEL_W-1:0] RESET_FIRST = 6'd0;
    localparam logic [MODEL_W-1:0] RESET_LAST  = 6'd63;

    // Step codes
    localparam logic [STEP_W-1:0] STEP_STAY = 2'd0;
    localparam logic [STEP_W-1:0] STEP_DOWN = 2'd1;
    localparam logic [STEP_W-1:0] STEP_UP   = 2'd2;

    // Warm-up: more than this many events before stepping starts
    localparam int WARM_W = 4;
    localparam logic [WARM_W-1:0] WARMUP_LIMIT = 4'd10;

    // Divide by 100 as multiply by ceil(2^19 / 100) and shift; exact below 43690,
    // and above that both quotients lie far beyond any model index
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] OCC_RECIP = 13'd5243;
    localparam int OCC_SHIFT = 19;
    localparam int PROD_W    = OCC_W + RECIP_W;
    localparam int QUOT_W    = PROD_W - OCC_SHIFT;

    // Decision handed from the selector to the result stages
    typedef struct packed {
        logic [MODEL_W-1:0] model;
        logic [STEP_W-1:0]  step;
        logic               warm;
    } t_sel_result;

endpackage

// ----- rtl/lams_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module lams_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lams_select.sv -----
// Model selector: trend history, warm-up count, ceiling and current model.
`timescale 1ns / 1ps
module lams_select #(
    parameter int TREND_DEPTH = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lams_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lams_pkg::MODEL_W-1:0]   i_cfg_data,
    input  logic                           i_fire,
    input  logic [lams_pkg::OCC_W-1:0]     i_occupancy,
    output lams_pkg::t_sel_result          o_result
);
    import lams_pkg::*;

    localparam int HIST_LEN = TREND_DEPTH - 1;

    logic [MODEL_W-1:0] r_first;
    logic [MODEL_W-1:0] r_last;
    logic [MODEL_W-1:0] r_cur;
    logic [WARM_W-1:0]  r_warm_cnt;
    logic [OCC_W-1:0]   r_hist [HIST_LEN];

    logic [WARM_W-1:0]  n_warm_cnt;
    logic [MODEL_W-1:0] n_cur;
    logic [MODEL_W-1:0] n_first;
    logic [MODEL_W-1:0] n_last;
    logic [MODEL_W:0]   mid_sum;
    logic               warm;
    logic [OCC_W-1:0]   remaining;
    logic [PROD_W-1:0]  prod;
    logic [QUOT_W-1:0]  quot;
    logic [MODEL_W-1:0] ceil_raw;
    logic [MODEL_W-1:0] ceiling;
    logic               rising;
    logic               falling;
    logic [STEP_W-1:0]  step;

    // Warm-up counter saturates one past the limit
    always_comb begin
        n_warm_cnt = (r_warm_cnt <= WARMUP_LIMIT) ? r_warm_cnt + 4'd1 : r_warm_cnt;
        warm       = (n_warm_cnt > WARMUP_LIMIT);
    end

    // Ceiling: last model less (occupancy - 1) / 100, first model if out of range
    always_comb begin
        remaining = (i_occupancy != '0) ? i_occupancy - OCC_W'(1) : '0;
        prod      = PROD_W'(remaining) * PROD_W'(OCC_RECIP);
        quot      = prod[PROD_W-1:OCC_SHIFT];
        ceil_raw  = r_last - quot[MODEL_W-1:0];
        if (quot > QUOT_W'(r_last)) begin
            ceiling = r_first;
        end else if (ceil_raw < r_first) begin
            ceiling = r_first;
        end else begin
            ceiling = ceil_raw;
        end
    end

    // Trend against the entry written TREND_DEPTH-1 events ago
    assign rising  = (i_occupancy > r_hist[HIST_LEN-1]);
    assign falling = (i_occupancy < r_hist[HIST_LEN-1]);

    // Step decision
    always_comb begin
        n_cur = r_cur;
        step  = STEP_STAY;
        if (warm) begin
            if (rising && (r_cur > r_first)) begin
                n_cur = r_cur - 6'd1;
                step  = STEP_DOWN;
            end else if (falling && (r_cur < ceiling)) begin
                n_cur = r_cur + 6'd1;
                step  = STEP_UP;
            end
        end
    end

    assign o_result = '{model: n_cur, step: step, warm: warm};

    // Register writes; either one recentres the model index
    always_comb begin
        n_first = r_first;
        n_last  = r_last;
        case (i_cfg_index)
            CFG_FIRST_MODEL: n_first = i_cfg_data;
            CFG_LAST_MODEL:  n_last  = i_cfg_data;
            default: ;
        endcase
        mid_sum = {1'b0, n_first} + {1'b0, n_last};
    end

    // Selector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= RESET_FIRST;
            r_last     <= RESET_LAST;
            r_cur      <= MODEL_W'(({1'b0, RESET_FIRST} + {1'b0, RESET_LAST}) >> 1);
            r_warm_cnt <= '0;
            for (int k = 0; k < HIST_LEN; k++) begin
                r_hist[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if ((i_cfg_index == CFG_FIRST_MODEL) || (i_cfg_index == CFG_LAST_MODEL)) begin
                r_first <= n_first;
                r_last  <= n_last;
                r_cur   <= mid_sum[MODEL_W:1];
            end
        end else if (i_fire) begin
            r_cur      <= n_cur;
            r_warm_cnt <= n_warm_cnt;
            r_hist[0]  <= i_occupancy;
            for (int k = 1; k < HIST_LEN; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

endmodule

// ----- rtl/lams_count.sv -----
// Per-model use counters: RAM read-modify-write with valid bits and forwarding.
`timescale 1ns / 1ps
module lams_count #(
    parameter int MODEL_COUNT = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [lams_pkg::MODEL_W-1:0] i_rd_model,
    input  logic                         i_wr_en,
    output logic [lams_pkg::COUNT_W-1:0] o_count
);
    import lams_pkg::*;

    localparam int IDX_W = $clog2(MODEL_COUNT);

    logic [MODEL_COUNT-1:0] r_valid;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_known;
    logic                   r_fwd;
    logic [COUNT_W-1:0]     r_fwd_data;

    logic [IDX_W-1:0]       rd_idx;
    logic [COUNT_W-1:0]     ram_rdata;
    logic [COUNT_W-1:0]     base;
    logic [COUNT_W-1:0]     n_count;

    // Models beyond the counter array share the top counter
    always_comb begin
        if (32'(i_rd_model) >= MODEL_COUNT) begin
            rd_idx = IDX_W'(MODEL_COUNT - 1);
        end else begin
            rd_idx = IDX_W'(i_rd_model);
        end
    end

    lams_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MODEL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (r_idx),
        .i_wdata (n_count),
        .i_re    (i_rd_en),
        .i_raddr (rd_idx),
        .o_rdata (ram_rdata)
    );

    // Never-written counters read as zero; a write in the read cycle is forwarded
    always_comb begin
        if (r_fwd) begin
            base = r_fwd_data;
        end else if (r_known) begin
            base = ram_rdata;
        end else begin
            base = '0;
        end
        n_count = base + COUNT_W'(1);
    end

    assign o_count = n_count;

    // Index and forwarding state of the transaction whose count is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_known <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_known <= r_valid[rd_idx];
                r_fwd   <= i_wr_en && (r_idx == rd_idx);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_idx      <= rd_idx;
            r_fwd_data <= n_count;
        end
    end

endmodule

// ----- rtl/load_adaptive_model_selector_unit.sv -----
// Top level of the load adaptive model selector.
`timescale 1ns / 1ps
// Picks a model index for every dequeue transaction from the queue occupancy
// trend and reports that model's running use count. One transaction is taken
// every clock cycle while the input is not stalled; a result passes through
// the first stage register and then the result register. The use-count RAM,
// with its registered read, is read on acceptance and written back when the
// result register takes the transaction (a write to the same counter in the
// read cycle is forwarded). A stalled result holds the input off once both
// stages are full. Counters need no clearing pass: one valid flip-flop per
// model makes an unwritten counter read as zero. Register writes (index 0
// first model, 1 last model) are always ready and recentre the model index.
module load_adaptive_model_selector_unit #(
    parameter int TREND_DEPTH = 3,
    parameter int MODEL_COUNT = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [lams_pkg::OCC_W-1:0]     i_queue_occupancy,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [lams_pkg::MODEL_W-1:0]   o_model_index,
    output logic [lams_pkg::STEP_W-1:0]    o_step_taken,
    output logic                           o_warmed_up,
    output logic [lams_pkg::COUNT_W-1:0]   o_use_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lams_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lams_pkg::MODEL_W-1:0]   i_cfg_data
);
    import lams_pkg::*;

    logic          r_s1_valid;
    t_sel_result   r_s1_sel;
    logic          r_out_valid;
    t_sel_result   r_out_sel;
    logic [COUNT_W-1:0] r_out_count;

    t_sel_result   sel_result;
    logic [COUNT_W-1:0] count;
    logic          s1_adv;
    logic          in_fire;
    logic          cfg_we;

    // Handshake: the output register frees the first stage when it drains
    assign s1_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    lams_select #(
        .TREND_DEPTH (TREND_DEPTH)
    ) u_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (in_fire),
        .i_occupancy (i_queue_occupancy),
        .o_result    (sel_result)
    );

    lams_count #(
        .MODEL_COUNT (MODEL_COUNT)
    ) u_count (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_fire),
        .i_rd_model (sel_result.model),
        .i_wr_en    (r_s1_valid && s1_adv),
        .o_count    (count)
    );

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_sel <= sel_result;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_sel   <= r_s1_sel;
            r_out_count <= count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_model_index = r_out_sel.model;
    assign o_step_taken  = r_out_sel.step;
    assign o_warmed_up   = r_out_sel.warm;
    assign o_use_count   = r_out_count;

endmodule

// ----- rtl/lams_checker.sv -----
// Port-level checks for the load adaptive model selector, bound to the top level.
`timescale 1ns / 1ps
module lams_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [lams_pkg::MODEL_W-1:0]   o_model_index,
    input logic [lams_pkg::STEP_W-1:0]    o_step_taken,
    input logic                           o_warmed_up,
    input logic [lams_pkg::COUNT_W-1:0]   o_use_count
);
    import lams_pkg::*;

    // A stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result transaction keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_model_index) && $stable(o_step_taken)
            && $stable(o_warmed_up) && $stable(o_use_count))
        else $error("result payload changed while stalled");

    // Only defined step codes are reported
    a_step_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_step_taken == STEP_STAY) || (o_step_taken == STEP_DOWN)
            || (o_step_taken == STEP_UP))
        else $error("undefined step code");

    // No step is taken during warm-up
    a_step_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_step_taken != STEP_STAY) |-> o_warmed_up)
        else $error("step taken before warm-up finished");

    // With the result stage empty the input side is never stalled
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with an empty output");

endmodule

bind load_adaptive_model_selector_unit lams_checker u_lams_checker (.*);
